// ===== rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int STATUS_W       = 2;
    localparam int SLOT_W         = 4;
    localparam int TABLE_SIZE_DEF = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                     en;
        logic                     used;
        logic [KEY_W-1:0]         key;
        logic signed [VAL_W-1:0]  value;
    } wr_t;

endpackage

// ===== rtl/lpht_if.sv =====
`timescale 1ns / 1ps

interface lpht_req_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [lpht_pkg::KEY_W-1:0]          key;
    logic signed [lpht_pkg::VAL_W-1:0]   value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink (input valid, input op, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [lpht_pkg::STATUS_W-1:0]       status;
    logic signed [lpht_pkg::VAL_W-1:0]   found_value;
    logic [lpht_pkg::SLOT_W-1:0]         slot;

    modport source (output valid, output status, output found_value, output slot, input ready);
    modport sink (input valid, input status, input found_value, input slot, output ready);
endinterface

// ===== rtl/lpht_store.sv =====
`timescale 1ns / 1ps

module lpht_store #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic                               clk,
    input  logic [$clog2(TABLE_SIZE)-1:0]      wr_addr,
    input  lpht_pkg::wr_t                      wr,
    input  logic [$clog2(TABLE_SIZE)-1:0]      rd_addr,
    output logic                               rd_used,
    output logic [lpht_pkg::KEY_W-1:0]         rd_key,
    output logic signed [lpht_pkg::VAL_W-1:0]  rd_value
);

    logic                              used_mem  [TABLE_SIZE];
    logic [lpht_pkg::KEY_W-1:0]        key_mem   [TABLE_SIZE];
    logic signed [lpht_pkg::VAL_W-1:0] value_mem [TABLE_SIZE];

    logic                              rd_used_reg;
    logic [lpht_pkg::KEY_W-1:0]        rd_key_reg;
    logic signed [lpht_pkg::VAL_W-1:0] rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            used_mem[wr_addr] <= wr.used;
            if (wr.used)
            begin
                key_mem[wr_addr]   <= wr.key;
                value_mem[wr_addr] <= wr.value;
            end
        end
        rd_used_reg  <= used_mem[rd_addr];
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    assign rd_used  = rd_used_reg;
    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule

// ===== rtl/linear_probe_hash_table_top.sv =====
`timescale 1ns / 1ps

// channel  modport  payload                          handshake
// req      sink     op, key, value                   valid/ready
// rsp      source   status, found_value, slot        valid/ready
//
// an item is accepted, then the home slot is reckoned from the 4 key bytes, msb first,
// each through the reciprocal multiply remainder unit in a quotient and a remainder step,
// then 1 to TABLE_SIZE slots are probed through the table store (one write, one read port)
// after reset a clearing pass over all TABLE_SIZE slots resets the used marks, req.ready is low
// the result sits in an output register; a stalled rsp holds the last probe until it drains
// req.ready is high only while no item is in progress

module linear_probe_hash_table_top #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lpht_req_if.sink    req,
    lpht_rsp_if.source  rsp
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int CHUNK_W = 8;
    localparam int STEPS   = 2 * lpht_pkg::KEY_W / CHUNK_W;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int X_W     = IDX_W + CHUNK_W;
    localparam logic [X_W-1:0]    SIZE_X    = X_W'(TABLE_SIZE);
    localparam logic [X_W-1:0]    RECIP     = X_W'((1 << X_W) / TABLE_SIZE);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_SIZE - 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_MOD, S_PROBE} state_t;

    state_t                               state_reg, state_next;
    logic [IDX_W-1:0]                     idx_reg, idx_next;
    logic [IDX_W-1:0]                     cnt_reg, cnt_next;
    logic [STEP_W-1:0]                    step_reg, step_next;
    logic [CHUNK_W-1:0]                   quot_reg, quot_next;
    logic                                 op_reg, op_next;
    logic [lpht_pkg::KEY_W-1:0]           key_reg, key_next;
    logic [lpht_pkg::KEY_W-1:0]           key_sh_reg, key_sh_next;
    logic signed [lpht_pkg::VAL_W-1:0]    value_reg, value_next;
    logic                                 rsp_valid_reg, rsp_valid_next;
    logic [lpht_pkg::STATUS_W-1:0]        status_reg, status_next;
    logic signed [lpht_pkg::VAL_W-1:0]    found_value_reg, found_value_next;
    logic [lpht_pkg::SLOT_W-1:0]          slot_reg, slot_next;

    logic [X_W-1:0]                       mod_x;
    logic [X_W+CHUNK_W-1:0]               mod_prod;
    logic [X_W-1:0]                       mod_rem;
    logic [X_W-1:0]                       mod_red;
    logic [IDX_W-1:0]                     idx_wrap;
    logic                                 rsp_free;
    logic                                 done;
    logic                                 do_write;
    logic [lpht_pkg::STATUS_W-1:0]        res_status;
    logic signed [lpht_pkg::VAL_W-1:0]    res_value;
    logic [lpht_pkg::SLOT_W-1:0]          res_slot;

    lpht_pkg::wr_t                        wr;
    logic                                 rd_used;
    logic [lpht_pkg::KEY_W-1:0]           rd_key;
    logic signed [lpht_pkg::VAL_W-1:0]    rd_value;

    lpht_store #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_store (
        .clk      (clk),
        .wr_addr  (idx_reg),
        .wr       (wr),
        .rd_addr  (idx_next),
        .rd_used  (rd_used),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // key mod TABLE_SIZE one key byte at a time, msb first, each in a quotient and a remainder step
    // quotient estimate by reciprocal, then remainder with one correction
    assign mod_x     = {idx_reg, key_sh_reg[lpht_pkg::KEY_W-1 -: CHUNK_W]};
    assign mod_prod  = (X_W + CHUNK_W)'(mod_x) * (X_W + CHUNK_W)'(RECIP);
    assign mod_rem   = mod_x - X_W'(quot_reg) * SIZE_X;
    assign mod_red   = (mod_rem >= SIZE_X) ? (mod_rem - SIZE_X) : mod_rem;
    assign idx_wrap  = (idx_reg == LAST_IDX) ? '0 : (idx_reg + 1'b1);
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // probe decision on the slot at idx_reg
    always_comb
    begin
        done       = 1'b0;
        do_write   = 1'b0;
        res_status = lpht_pkg::ST_NOT_FOUND;
        res_value  = '0;
        res_slot   = '0;
        if (op_reg == lpht_pkg::OP_INSERT)
        begin
            if (!rd_used)
            begin
                done       = 1'b1;
                do_write   = 1'b1;
                res_status = lpht_pkg::ST_INSERTED;
                res_slot   = lpht_pkg::SLOT_W'(idx_reg);
            end
        end
        else
        begin
            if (!rd_used)
            begin
                done       = 1'b1;
                res_status = lpht_pkg::ST_NOT_FOUND;
            end
            else if (rd_key == key_reg)
            begin
                done       = 1'b1;
                res_status = lpht_pkg::ST_FOUND;
                res_value  = rd_value;
                res_slot   = lpht_pkg::SLOT_W'(idx_reg);
            end
        end
        if (!done && cnt_reg == LAST_IDX)
        begin
            done       = 1'b1;
            res_status = (op_reg == lpht_pkg::OP_INSERT) ? lpht_pkg::ST_FULL
                                                        : lpht_pkg::ST_NOT_FOUND;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        step_next        = step_reg;
        quot_next        = quot_reg;
        op_next          = op_reg;
        key_next         = key_reg;
        key_sh_next      = key_sh_reg;
        value_next       = value_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        status_next      = status_reg;
        found_value_next = found_value_reg;
        slot_next        = slot_reg;
        wr.en            = 1'b0;
        wr.used          = 1'b1;
        wr.key           = key_reg;
        wr.value         = value_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr.en   = 1'b1;
                wr.used = 1'b0;
                idx_next = idx_wrap;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    key_next    = req.key;
                    key_sh_next = req.key;
                    value_next  = req.value;
                    idx_next    = '0;
                    step_next   = '0;
                    state_next  = S_MOD;
                end
            end
            S_MOD:
            begin
                step_next = step_reg + 1'b1;
                if (!step_reg[0])
                begin
                    quot_next = mod_prod[X_W +: CHUNK_W];
                end
                else
                begin
                    idx_next    = mod_red[IDX_W-1:0];
                    key_sh_next = key_sh_reg << CHUNK_W;
                end
                if (step_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (done)
                begin
                    if (rsp_free)
                    begin
                        wr.en            = do_write;
                        rsp_valid_next   = 1'b1;
                        status_next      = res_status;
                        found_value_next = res_value;
                        slot_next        = res_slot;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_wrap;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            step_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            cnt_reg         <= cnt_next;
            step_reg        <= step_next;
            quot_reg        <= quot_next;
            rsp_valid_reg   <= rsp_valid_next;
            op_reg          <= op_next;
            key_reg         <= key_next;
            key_sh_reg      <= key_sh_next;
            value_reg       <= value_next;
            status_reg      <= status_next;
            found_value_reg <= found_value_next;
            slot_reg        <= slot_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_value = found_value_reg;
    assign rsp.slot        = slot_reg;

endmodule
